// ===== sv/mqttfh_pkg.sv =====
package mqttfh_pkg;

    localparam int DataW          = 8;
    localparam int NibbleW        = 4;
    localparam int LenW           = 28;
    localparam int GroupW         = 7;
    localparam int LevelW         = 3;
    localparam int MaxLengthBytes = 4;
    localparam int LenIdxW        = 2;

    localparam logic [LevelW-1:0] LevelReset    = 3'd4;
    localparam logic [LevelW-1:0] LevelWithBody = 3'd5;

    typedef enum logic [1:0] {
        RoleType   = 2'd0,
        RoleLength = 2'd1,
        RoleBody   = 2'd2
    } t_role;

    typedef enum logic [2:0] {
        ErrNone       = 3'd0,
        ErrTypeZero   = 3'd1,
        ErrBadFlags   = 3'd2,
        ErrLenOvf     = 3'd3,
        ErrPublish    = 3'd4,
        ErrDisconnect = 3'd5
    } t_err;

    localparam logic [NibbleW-1:0] KindReserved   = 4'd0;
    localparam logic [NibbleW-1:0] KindPublish    = 4'd3;
    localparam logic [NibbleW-1:0] KindPubrel     = 4'd6;
    localparam logic [NibbleW-1:0] KindSubscribe  = 4'd8;
    localparam logic [NibbleW-1:0] KindUnsub      = 4'd10;
    localparam logic [NibbleW-1:0] KindDisconnect = 4'd14;

    localparam logic [NibbleW-1:0] FlagsZero = 4'd0;
    localparam logic [NibbleW-1:0] FlagsTwo  = 4'd2;
    localparam logic [1:0]         QosZero   = 2'd0;
    localparam logic [1:0]         QosBad    = 2'd3;

endpackage

// ===== sv/mqttfh_if.sv =====
interface mqttfh_in_if import mqttfh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DataW-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

interface mqttfh_out_if import mqttfh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [DataW-1:0]   byte_out;
    logic [1:0]         byte_role;
    logic [NibbleW-1:0] packet_kind;
    logic [NibbleW-1:0] packet_flags;
    logic [LenW-1:0]    body_length;
    logic               length_done;
    logic               packet_end;
    logic [2:0]         error_code;

    modport source (
        output valid, output byte_out, output byte_role, output packet_kind,
        output packet_flags, output body_length, output length_done,
        output packet_end, output error_code, input ready
    );
    modport sink (
        input valid, input byte_out, input byte_role, input packet_kind,
        input packet_flags, input body_length, input length_done,
        input packet_end, input error_code, output ready
    );
endinterface

// ===== sv/mqttfh_in_stage.sv =====
module mqttfh_in_stage import mqttfh_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mqttfh_in_if.sink   i_in,
    mqttfh_in_if.source o_in
);

    logic             r_valid;
    logic [DataW-1:0] r_byte;

    assign i_in.ready     = !r_valid || o_in.ready;
    assign o_in.valid     = r_valid;
    assign o_in.data_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_byte <= i_in.data_byte;
        end
    end

endmodule

// ===== sv/mqttfh_framer.sv =====
module mqttfh_framer import mqttfh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [LevelW-1:0] i_level,
    mqttfh_in_if.sink         i_in,
    mqttfh_out_if.source      o_out
);

    typedef enum logic [1:0] {
        PhType = 2'd0,
        PhLen  = 2'd1,
        PhBody = 2'd2
    } t_phase;

    t_phase             r_phase, n_phase;
    logic [NibbleW-1:0] r_kind, n_kind;
    logic [NibbleW-1:0] r_flags, n_flags;
    logic [LenW-1:0]    r_accum, n_accum;
    logic [LenIdxW-1:0] r_idx, n_idx;
    logic [LenW-1:0]    r_left, n_left;
    t_err               r_err, n_err;

    logic               r_out_valid;
    logic [DataW-1:0]   r_byte_out;
    t_role              r_role, n_role;
    logic [LenW-1:0]    r_blen, n_blen;
    logic               r_done, n_done;
    logic               r_pend, n_pend;

    logic               accept;
    logic [DataW-1:0]   b;
    logic [LenW-1:0]    group;
    logic [LenW-1:0]    sum;
    logic [LenW-1:0]    left_dec;
    logic [LenIdxW:0]   idx_inc;

    function automatic t_err check_type(logic [NibbleW-1:0] kind,
                                        logic [NibbleW-1:0] flags);
        logic [NibbleW-1:0] need;
        logic [1:0]         qos;
        need = FlagsZero;
        qos  = flags[2:1];
        case (kind)
            KindPubrel, KindSubscribe, KindUnsub: need = FlagsTwo;
            default:                              need = FlagsZero;
        endcase
        if (kind == KindReserved) begin
            return ErrTypeZero;
        end else if (kind == KindPublish) begin
            if (qos == QosBad || (qos == QosZero && flags[3])) begin
                return ErrPublish;
            end
            return ErrNone;
        end else if (flags != need) begin
            return ErrBadFlags;
        end
        return ErrNone;
    endfunction

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;
    assign b          = i_in.data_byte;

    assign group    = LenW'(b[GroupW-1:0]) << (5'(r_idx) * 5'(GroupW));
    assign sum      = r_accum + group;
    assign left_dec = r_left - LenW'(1);
    assign idx_inc  = {1'b0, r_idx} + (LenIdxW+1)'(1);

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_flags = r_flags;
        n_accum = r_accum;
        n_idx   = r_idx;
        n_left  = r_left;
        n_err   = r_err;
        n_role  = RoleBody;
        n_blen  = '0;
        n_done  = 1'b0;
        n_pend  = 1'b0;
        if (r_err != ErrNone) begin
            n_blen = r_accum;
        end else begin
            unique case (r_phase)
                PhLen: begin
                    n_role  = RoleLength;
                    n_accum = sum;
                    n_blen  = sum;
                    if (b[DataW-1]) begin
                        if (32'(idx_inc) >= MaxLengthBytes) begin
                            n_err = ErrLenOvf;
                        end else begin
                            n_idx = idx_inc[LenIdxW-1:0];
                        end
                    end else begin
                        n_done = 1'b1;
                        if (r_kind == KindDisconnect && sum != '0 &&
                            i_level < LevelWithBody) begin
                            n_err = ErrDisconnect;
                        end else if (sum == '0) begin
                            n_pend  = 1'b1;
                            n_phase = PhType;
                        end else begin
                            n_left  = sum;
                            n_phase = PhBody;
                        end
                    end
                end
                PhBody: begin
                    n_blen = r_accum;
                    n_done = 1'b1;
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        n_pend  = 1'b1;
                        n_phase = PhType;
                    end
                end
                default: begin
                    n_role  = RoleType;
                    n_kind  = b[DataW-1:NibbleW];
                    n_flags = b[NibbleW-1:0];
                    n_accum = '0;
                    n_idx   = '0;
                    n_left  = '0;
                    n_phase = PhLen;
                    n_err   = check_type(b[DataW-1:NibbleW], b[NibbleW-1:0]);
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PhType;
            r_kind      <= '0;
            r_flags     <= '0;
            r_accum     <= '0;
            r_idx       <= '0;
            r_left      <= '0;
            r_err       <= ErrNone;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_out_valid <= i_in.valid;
            end
            if (accept) begin
                r_phase <= n_phase;
                r_kind  <= n_kind;
                r_flags <= n_flags;
                r_accum <= n_accum;
                r_idx   <= n_idx;
                r_left  <= n_left;
                r_err   <= n_err;
            end
        end
        if (accept) begin
            r_byte_out <= b;
            r_role     <= n_role;
            r_blen     <= n_blen;
            r_done     <= n_done;
            r_pend     <= n_pend;
        end
    end

    // Kind, flags and error always reflect the state left by the last item.
    assign o_out.valid        = r_out_valid;
    assign o_out.byte_out     = r_byte_out;
    assign o_out.byte_role    = r_role;
    assign o_out.packet_kind  = r_kind;
    assign o_out.packet_flags = r_flags;
    assign o_out.body_length  = r_blen;
    assign o_out.length_done  = r_done;
    assign o_out.packet_end   = r_pend;
    assign o_out.error_code   = r_err;

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ErrNone |=> r_err == $past(r_err))
        else $error("sticky error changed");

    a_body_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PhBody |-> r_left != '0)
        else $error("body phase with no bytes left");

    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_pend |-> r_done && r_err == ErrNone)
        else $error("packet end without complete length");

    a_halt_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err != ErrNone |=> r_phase == $past(r_phase) && r_accum == $past(r_accum))
        else $error("framing state moved after error");

endmodule

// ===== sv/mqtt_fixed_header_framer_core.sv =====
// Channel  Direction  Handshake              Payload
// i_in     in         valid / ready          data_byte
// o_out    out        valid / ready          byte_out .. error_code
// cfg      in         i_cfg_we               i_cfg_wdata (protocol level)
//
// One byte is accepted every cycle while o_out does not stall; each result passes through
// the input register and the result register. Each of these registers takes a new item while
// the next stage drains, so throughput is set by the combinational framing step.
// A stall on o_out backs up through both registers to i_in.ready.
// Reset is synchronous on i_rst_n and sets protocol level 4 with no error.
module mqtt_fixed_header_framer_core import mqttfh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mqttfh_in_if.sink         i_in,
    mqttfh_out_if.source      o_out,
    input  logic              i_cfg_we,
    input  logic [LevelW-1:0] i_cfg_wdata
);

    logic [LevelW-1:0] r_level;

    mqttfh_in_if u_stage_if ();

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LevelReset;
        end else if (i_cfg_we) begin
            r_level <= i_cfg_wdata;
        end
    end

    mqttfh_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_in    (u_stage_if.source)
    );

    mqttfh_framer u_framer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_level (r_level),
        .i_in    (u_stage_if.sink),
        .o_out   (o_out)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import mqttfh_pkg::*;

    localparam int NumDirected = 25;
    localparam int DrainCycles = 6;
    localparam int HoldCycles  = 64;
    localparam int TailBytes   = 30;

    typedef enum logic [1:0] {
        AwaitType  = 2'd0,
        ReadLength = 2'd1,
        ReadBody   = 2'd2
    } t_frame_phase;

    typedef enum int {
        EndTypeZero,
        EndBadFlags,
        EndLenOvf,
        EndPublish,
        EndDisconnect,
        EndHugeLength
    } t_ending;

    typedef struct packed {
        logic [DataW-1:0]   byte_val;
        logic [1:0]         role;
        logic [NibbleW-1:0] kind;
        logic [NibbleW-1:0] flags;
        logic [LenW-1:0]    blen;
        logic               done;
        logic               pend;
        logic [2:0]         err;
    } t_frame_result;

    typedef struct packed {
        logic [DataW-1:0] data;
        logic             typed;
        t_frame_result    want;
    } t_directed_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [LevelW-1:0] i_cfg_wdata;

    mqttfh_in_if  in_if ();
    mqttfh_out_if out_if ();

    mqtt_fixed_header_framer_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [LevelW-1:0]  level_q  = LevelReset;
    t_frame_phase       fr_phase = AwaitType;
    logic [NibbleW-1:0] fr_kind  = '0;
    logic [NibbleW-1:0] fr_flags = '0;
    logic [LenW-1:0]    fr_accum = '0;
    logic [LenW-1:0]    fr_left  = '0;
    logic [LenIdxW-1:0] fr_idx   = '0;
    t_err               fr_err   = ErrNone;

    t_frame_result expected_frames [$];
    int unsigned   mismatch_count = 0;
    int unsigned   bytes_accepted = 0;
    int unsigned   send_idle_pct  = 0;
    int unsigned   stall_pct      = 0;
    bit            hold_request   = 1'b0;

    t_directed_row directed_rows [NumDirected] = '{
        '{8'h10, 1'b1, '{8'h10, RoleType,   4'd1,  4'd0, 28'd0, 1'b0, 1'b0, ErrNone}},
        '{8'h02, 1'b1, '{8'h02, RoleLength, 4'd1,  4'd0, 28'd2, 1'b1, 1'b0, ErrNone}},
        '{8'h00, 1'b1, '{8'h00, RoleBody,   4'd1,  4'd0, 28'd2, 1'b1, 1'b0, ErrNone}},
        '{8'hFF, 1'b1, '{8'hFF, RoleBody,   4'd1,  4'd0, 28'd2, 1'b1, 1'b1, ErrNone}},
        '{8'hC0, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h00, RoleLength, 4'd12, 4'd0, 28'd0, 1'b1, 1'b1, ErrNone}},
        '{8'h3D, 1'b0, '0},
        '{8'h81, 1'b1, '{8'h81, RoleLength, 4'd3, 4'd13, 28'd1, 1'b0, 1'b0, ErrNone}},
        '{8'h80, 1'b0, '0},
        '{8'h80, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h00, RoleLength, 4'd3, 4'd13, 28'd1, 1'b1, 1'b0, ErrNone}},
        '{8'h5A, 1'b0, '0},
        '{8'h62, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h82, 1'b0, '0},
        '{8'h01, 1'b0, '0},
        '{8'hA5, 1'b0, '0},
        '{8'hA2, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'hE0, 1'b0, '0},
        '{8'h00, 1'b1, '{8'h00, RoleLength, 4'd14, 4'd0, 28'd0, 1'b1, 1'b1, ErrNone}},
        '{8'hF0, 1'b0, '0},
        '{8'h00, 1'b0, '0},
        '{8'h3B, 1'b0, '0},
        '{8'h00, 1'b0, '0}
    };

    function automatic t_frame_result frame_next_byte(input logic [DataW-1:0] b);
        t_frame_result r;
        logic [1:0] qos;
        r = '0;
        r.byte_val = b;
        r.role = RoleBody;
        if (fr_err != ErrNone) begin
            r.blen = fr_accum;
        end else if (fr_phase == ReadLength) begin
            r.role = RoleLength;
            fr_accum = fr_accum + (LenW'(b[GroupW-1:0]) << (GroupW * fr_idx));
            r.blen = fr_accum;
            if (b[DataW-1]) begin
                if (fr_idx == LenIdxW'(MaxLengthBytes - 1)) begin
                    fr_err = ErrLenOvf;
                end else begin
                    fr_idx = fr_idx + 1'b1;
                end
            end else begin
                r.done = 1'b1;
                if (fr_kind == KindDisconnect && fr_accum != '0 && level_q < LevelWithBody) begin
                    fr_err = ErrDisconnect;
                end else if (fr_accum == '0) begin
                    r.pend = 1'b1;
                    fr_phase = AwaitType;
                end else begin
                    fr_left = fr_accum;
                    fr_phase = ReadBody;
                end
            end
        end else if (fr_phase == ReadBody) begin
            r.blen = fr_accum;
            r.done = 1'b1;
            fr_left = fr_left - 1'b1;
            if (fr_left == '0) begin
                r.pend = 1'b1;
                fr_phase = AwaitType;
            end
        end else begin
            r.role = RoleType;
            fr_kind = b[7:4];
            fr_flags = b[3:0];
            fr_accum = '0;
            fr_idx = '0;
            fr_left = '0;
            fr_phase = ReadLength;
            qos = b[2:1];
            if (fr_kind == KindReserved) begin
                fr_err = ErrTypeZero;
            end else if (fr_kind == KindPublish) begin
                fr_err = (qos == QosBad || (qos == QosZero && b[3])) ? ErrPublish : ErrNone;
            end else if (fr_kind == KindPubrel || fr_kind == KindSubscribe
                         || fr_kind == KindUnsub) begin
                fr_err = (fr_flags != FlagsTwo) ? ErrBadFlags : ErrNone;
            end else begin
                fr_err = (fr_flags != FlagsZero) ? ErrBadFlags : ErrNone;
            end
        end
        r.kind = fr_kind;
        r.flags = fr_flags;
        r.err = fr_err;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken.
    task automatic offer_byte(input logic [DataW-1:0] b, input logic typed,
                              input t_frame_result typed_want);
        t_frame_result predicted;
        if ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_if.valid <= 1'b1;
        in_if.data_byte <= b;
        do @(posedge i_clk); while (!in_if.ready);
        predicted = frame_next_byte(b);
        expected_frames.push_back(typed ? typed_want : predicted);
        bytes_accepted++;
        @(negedge i_clk);
    endtask

    task automatic set_level(input logic [LevelW-1:0] lvl);
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= lvl;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        level_q = lvl;
    endtask

    task automatic send_random_packet();
        logic [NibbleW-1:0] kind;
        logic [NibbleW-1:0] flags;
        logic [1:0] qos;
        int unsigned body_len;
        int unsigned min_groups;
        int unsigned groups;
        int unsigned pick;
        kind = NibbleW'($urandom_range(1, 15));
        flags = (kind == KindPubrel || kind == KindSubscribe || kind == KindUnsub)
                ? FlagsTwo : FlagsZero;
        if (kind == KindPublish) begin
            qos = 2'($urandom_range(0, 2));
            flags = {(qos != QosZero) & 1'($urandom), qos, 1'($urandom)};
        end
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            body_len = 0;
        end else if (pick < 85) begin
            body_len = $urandom_range(1, 8);
        end else if (pick < 95) begin
            body_len = $urandom_range(9, 127);
        end else begin
            body_len = $urandom_range(128, 300);
        end
        if (kind == KindDisconnect && level_q < LevelWithBody) begin
            body_len = 0;
        end
        min_groups = (body_len > 127) ? 2 : 1;
        groups = ($urandom_range(0, 99) < 30) ? $urandom_range(min_groups, MaxLengthBytes)
                                              : min_groups;
        offer_byte({kind, flags}, 1'b0, '0);
        for (int g = 0; g < groups; g++) begin
            offer_byte({(g + 1 < groups), 7'(body_len >> (GroupW * g))}, 1'b0, '0);
        end
        repeat (body_len) offer_byte(8'($urandom), 1'b0, '0);
    endtask

    task automatic run_phase(input logic [LevelW-1:0] lvl, input int unsigned idle_pct,
                             input int unsigned stall, input int unsigned n_bytes,
                             input bit long_hold);
        int unsigned first;
        set_level(lvl);
        send_idle_pct = idle_pct;
        stall_pct = stall;
        hold_request = long_hold;
        first = bytes_accepted;
        while (bytes_accepted - first < n_bytes) send_random_packet();
        in_if.valid <= 1'b0;
    endtask

    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                out_if.ready <= 1'b0;
                repeat (HoldCycles - 1) @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_frame_result want;
        t_frame_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got = '{out_if.byte_out, out_if.byte_role, out_if.packet_kind, out_if.packet_flags,
                    out_if.body_length, out_if.length_done, out_if.packet_end,
                    out_if.error_code};
            if (expected_frames.size() == 0) begin
                $display("%0t: result with no item pending, byte %h", $time, got.byte_val);
                mismatch_count++;
            end else begin
                want = expected_frames.pop_front();
                if (got !== want) begin
                    $display({"%0t: expected byte %h role %0d kind %0d flags %h len %0d",
                              " done %0b end %0b err %0d"},
                             $time, want.byte_val, want.role, want.kind, want.flags, want.blen,
                             want.done, want.pend, want.err);
                    $display({"%0t: actual   byte %h role %0d kind %0d flags %h len %0d",
                              " done %0b end %0b err %0d"},
                             $time, got.byte_val, got.role, got.kind, got.flags, got.blen,
                             got.done, got.pend, got.err);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("testbench failed");
        $finish;
    end

    initial begin
        t_ending ending;
        logic [LevelW-1:0] end_level;
        logic [NibbleW-1:0] kind;
        logic [NibbleW-1:0] flags;
        logic [NibbleW-1:0] required;
        logic [DataW-1:0] tail [$];

        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        in_if.valid = 1'b0;
        in_if.data_byte = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NumDirected; i++) begin
            offer_byte(directed_rows[i].data, directed_rows[i].typed, directed_rows[i].want);
        end
        in_if.valid <= 1'b0;

        run_phase(3'd5, 0, 0, 140, 1'b1);
        run_phase(3'd7, 79, 0, 130, 1'b0);
        run_phase(3'd3, 0, 79, 130, 1'b0);
        run_phase(3'd0, 32, 32, 130, 1'b0);

        // Any fixed-header error halts framing until reset, so one is provoked only at the end.
        ending = t_ending'($urandom_range(0, 5));
        end_level = (ending == EndDisconnect) ? LevelW'($urandom_range(0, 4))
                                              : LevelW'($urandom_range(0, 7));
        set_level(end_level);
        case (ending)
            EndTypeZero: begin
                tail.push_back({KindReserved, 4'($urandom)});
            end
            EndBadFlags: begin
                do kind = 4'($urandom_range(1, 15)); while (kind == KindPublish);
                required = (kind == KindPubrel || kind == KindSubscribe || kind == KindUnsub)
                           ? FlagsTwo : FlagsZero;
                do flags = 4'($urandom); while (flags == required);
                tail.push_back({kind, flags});
            end
            EndLenOvf: begin
                tail.push_back({4'd2, FlagsZero});
                repeat (MaxLengthBytes) tail.push_back({1'b1, 7'($urandom)});
            end
            EndPublish: begin
                if ($urandom_range(0, 1) == 0) begin
                    tail.push_back({KindPublish, 1'($urandom), QosBad, 1'($urandom)});
                end else begin
                    tail.push_back({KindPublish, 1'b1, QosZero, 1'($urandom)});
                end
            end
            EndDisconnect: begin
                tail.push_back({KindDisconnect, FlagsZero});
                tail.push_back({1'b0, 7'($urandom_range(1, 127))});
            end
            default: begin
                tail.push_back({KindPublish, 4'd2});
                repeat (MaxLengthBytes - 1) tail.push_back(8'hFF);
                tail.push_back(8'h7F);
            end
        endcase
        repeat (TailBytes) tail.push_back(8'($urandom));
        foreach (tail[i]) offer_byte(tail[i], 1'b0, '0);
        in_if.valid <= 1'b0;

        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mqttfh_pkg.sv
sv/mqttfh_if.sv
sv/mqttfh_in_stage.sv
sv/mqttfh_framer.sv
sv/mqtt_fixed_header_framer_core.sv
tb/testbench.sv
